### design/hexrw_pkg.sv
// shared types, codes and helpers of the hex record writer
`default_nettype none
package hexrw_pkg;

   // input commands
   localparam logic [1:0] CMD_WRITE   = 2'd0;
   localparam logic [1:0] CMD_ADDRESS = 2'd1;
   localparam logic [1:0] CMD_SEGMENT = 2'd2;
   localparam logic [1:0] CMD_END     = 2'd3;

   // configuration register indexes
   localparam logic CSR_LINE_LENGTH  = 1'b0;
   localparam logic CSR_NEWLINE_CRLF = 1'b1;

   // output unit kinds
   localparam logic [1:0] EMIT_NONE    = 2'd0;
   localparam logic [1:0] EMIT_COLON   = 2'd1;
   localparam logic [1:0] EMIT_HEX     = 2'd2;
   localparam logic [1:0] EMIT_NEWLINE = 2'd3;

   // source of the byte shown as hex
   localparam logic [2:0] BSEL_CONST   = 3'd0;
   localparam logic [2:0] BSEL_LEN     = 3'd1;
   localparam logic [2:0] BSEL_ADDR_HI = 3'd2;
   localparam logic [2:0] BSEL_ADDR_LO = 3'd3;
   localparam logic [2:0] BSEL_WORD_HI = 3'd4;
   localparam logic [2:0] BSEL_WORD_LO = 3'd5;
   localparam logic [2:0] BSEL_BUF     = 3'd6;
   localparam logic [2:0] BSEL_CHK     = 3'd7;

   localparam logic [7:0] DEFAULT_LINE_LENGTH = 8'd16;
   localparam logic [7:0] TYPE_SEGMENT        = 8'h02;
   localparam logic [7:0] TYPE_LINEAR         = 8'h04;
   localparam logic [7:0] TYPE_EOF            = 8'h01;
   localparam logic [7:0] CHR_COLON           = 8'h3A;
   localparam logic [7:0] CHR_CR              = 8'h0D;
   localparam logic [7:0] CHR_LF              = 8'h0A;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  data_byte;
      logic [31:0] address;
      logic [15:0] segment;
   } req_type;

   typedef struct packed {
      logic [7:0] first_char;
      logic [7:0] second_char;
      logic       pair;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic [1:0] emit;
      logic [2:0] bsel;
      logic [7:0] const_byte;
      logic       store;
      logic       flush_done;
      logic       clr_need_lin;
      logic       set_addr;
      logic       set_seg;
      logic       ext_seg;
      logic       last;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       full;
      logic       fill_zero;
      logic       need_lin;
      logic       seg_diff;
      logic       out_free;
   } dp_status_type;

   function automatic logic [7:0] nibble_ascii(input logic [3:0] d);
      nibble_ascii = (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h37 + {4'd0, d});
   endfunction

endpackage
`default_nettype wire

### design/hexrw_dp.sv
// datapath: address and segment state, line buffer, checksum and output register
`default_nettype none
module hexrw_dp #(
   parameter int MAX_LINE_LENGTH = 16,
   parameter int CNT_W = 5,
   parameter int IDX_W = 4
) (
   input  wire                           clock,
   input  wire                           reset,
   input  hexrw_pkg::req_type            req_data,
   input  hexrw_pkg::dp_cmd_type         cmd,
   input  wire  [IDX_W-1:0]              buf_idx,
   output hexrw_pkg::dp_status_type      status,
   output logic [CNT_W-1:0]              fill,
   input  wire                           csr_valid,
   input  wire                           csr_index,
   input  wire  [7:0]                    csr_data,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output hexrw_pkg::rsp_type            rsp_data
);
   import hexrw_pkg::*;

   localparam logic [7:0] MAX_B = 8'(MAX_LINE_LENGTH);

   req_type          item_ff;
   logic [31:0]      cur_addr_ff, cur_addr_in;
   logic [15:0]      cur_seg_ff, cur_seg_in;
   logic             need_lin_ff, need_lin_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [7:0]       buf_ff [MAX_LINE_LENGTH];
   logic [7:0]       sum_ff, sum_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic [7:0]       line_len_ff, line_len_in;
   logic             crlf_ff, crlf_in;

   logic [7:0]  eff_len;
   logic [7:0]  fill_b;
   logic [15:0] word;
   logic [7:0]  byte_sel;
   logic [16:0] end_addr;

   assign fill_b  = {{(8 - CNT_W){1'b0}}, fill_ff};
   assign word    = cmd.ext_seg ? cur_seg_ff : cur_addr_ff[31:16];
   assign end_addr = {1'b0, cur_addr_ff[15:0]} + {{(17 - CNT_W){1'b0}}, fill_ff};

   always_comb begin
      eff_len = (line_len_ff == 8'd0) ? DEFAULT_LINE_LENGTH : line_len_ff;
      if (eff_len > MAX_B) begin
         eff_len = MAX_B;
      end
   end

   always_comb begin
      case (cmd.bsel)
         BSEL_CONST:   byte_sel = cmd.const_byte;
         BSEL_LEN:     byte_sel = fill_b;
         BSEL_ADDR_HI: byte_sel = cur_addr_ff[15:8];
         BSEL_ADDR_LO: byte_sel = cur_addr_ff[7:0];
         BSEL_WORD_HI: byte_sel = word[15:8];
         BSEL_WORD_LO: byte_sel = word[7:0];
         BSEL_BUF:     byte_sel = buf_ff[buf_idx];
         BSEL_CHK:     byte_sel = 8'd0 - sum_ff;
         default:      byte_sel = cmd.const_byte;
      endcase
   end

   always_comb begin
      cur_addr_in  = cur_addr_ff;
      cur_seg_in   = cur_seg_ff;
      need_lin_in  = need_lin_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      line_len_in  = line_len_ff;
      crlf_in      = crlf_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         if (csr_index == CSR_LINE_LENGTH) begin
            line_len_in = csr_data;
         end else begin
            crlf_in = csr_data[0];
         end
      end

      if (cmd.emit != EMIT_NONE) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.last = cmd.last;
      end
      case (cmd.emit)
         EMIT_COLON: begin
            rsp_data_in.first_char  = CHR_COLON;
            rsp_data_in.second_char = 8'd0;
            rsp_data_in.pair        = 1'b0;
            sum_in = 8'd0;
         end
         EMIT_HEX: begin
            rsp_data_in.first_char  = nibble_ascii(byte_sel[7:4]);
            rsp_data_in.second_char = nibble_ascii(byte_sel[3:0]);
            rsp_data_in.pair        = 1'b1;
            sum_in = sum_ff + byte_sel;
         end
         EMIT_NEWLINE: begin
            rsp_data_in.first_char  = crlf_ff ? CHR_CR : CHR_LF;
            rsp_data_in.second_char = crlf_ff ? CHR_LF : 8'd0;
            rsp_data_in.pair        = crlf_ff;
         end
         default: begin
         end
      endcase

      if (cmd.clr_need_lin) begin
         need_lin_in = 1'b0;
      end
      // record done: advance the address, note a 64K wrap and clear the fill
      if (cmd.flush_done) begin
         cur_addr_in = cur_addr_ff + {{(32 - CNT_W){1'b0}}, fill_ff};
         if (end_addr[16]) begin
            need_lin_in = 1'b1;
         end
         fill_in = '0;
      end
      if (cmd.set_addr) begin
         if (cur_addr_ff[31:16] != item_ff.address[31:16]) begin
            need_lin_in = 1'b1;
         end else if (cur_addr_ff != {item_ff.address[31:16], 16'h0000}) begin
            need_lin_in = 1'b0;
         end
         cur_addr_in = item_ff.address;
      end
      if (cmd.set_seg) begin
         cur_seg_in = item_ff.segment;
      end
      if (cmd.store) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_addr_ff  <= '0;
         cur_seg_ff   <= '0;
         need_lin_ff  <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         line_len_ff  <= DEFAULT_LINE_LENGTH;
         crlf_ff      <= 1'b1;
      end else begin
         cur_addr_ff  <= cur_addr_in;
         cur_seg_ff   <= cur_seg_in;
         need_lin_ff  <= need_lin_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         line_len_ff  <= line_len_in;
         crlf_ff      <= crlf_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (cmd.store) begin
         buf_ff[fill_ff[IDX_W-1:0]] <= item_ff.data_byte;
      end
   end

   assign status.cmd       = item_ff.command;
   assign status.full      = (fill_b >= eff_len);
   assign status.fill_zero = (fill_ff == '0);
   assign status.need_lin  = need_lin_ff;
   assign status.seg_diff  = (cur_seg_ff != item_ff.segment);
   assign status.out_free  = ~rsp_valid_ff | ~rsp_stall;

   assign fill      = fill_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

### design/hexrw_ctrl.sv
// controller: sequences the records and output units for each item
`default_nettype none
module hexrw_ctrl #(
   parameter int CNT_W = 5,
   parameter int IDX_W = 4
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  hexrw_pkg::dp_status_type      status,
   input  wire  [CNT_W-1:0]              fill,
   output hexrw_pkg::dp_cmd_type         cmd,
   output logic [IDX_W-1:0]              buf_idx
);
   import hexrw_pkg::*;

   localparam int STEP_W = (IDX_W > 4) ? IDX_W : 4;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_FLUSH    = 4'd2;
   localparam logic [3:0] S_EXT4     = 4'd3;
   localparam logic [3:0] S_HEAD     = 4'd4;
   localparam logic [3:0] S_BODY     = 4'd5;
   localparam logic [3:0] S_TAIL     = 4'd6;
   localparam logic [3:0] S_AFTER    = 4'd7;
   localparam logic [3:0] S_EOF      = 4'd8;
   localparam logic [3:0] S_EXT2     = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [1:0]        kind;
   logic              body_end;

   assign req_stall = (state_ff != S_IDLE);
   assign buf_idx   = cnt_ff[IDX_W-1:0];
   assign body_end  = (7'(cnt_ff) + 7'd1 == 7'(fill));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      kind     = EMIT_NONE;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.cmd == CMD_WRITE && !status.full) begin
               cmd.store = 1'b1;
               state_in  = S_IDLE;
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            cnt_in = '0;
            if (status.fill_zero) begin
               state_in = S_AFTER;
            end else if (status.need_lin) begin
               state_in = S_EXT4;
            end else begin
               state_in = S_HEAD;
            end
         end
         S_EXT4, S_EXT2: begin
            cmd.ext_seg = (state_ff == S_EXT2);
            cmd.bsel    = BSEL_CONST;
            kind        = EMIT_HEX;
            case (cnt_ff)
               4'd0: kind = EMIT_COLON;
               4'd1: cmd.const_byte = 8'h02;
               4'd4: cmd.const_byte = cmd.ext_seg ? TYPE_SEGMENT : TYPE_LINEAR;
               4'd5: cmd.bsel = BSEL_WORD_HI;
               4'd6: cmd.bsel = BSEL_WORD_LO;
               4'd7: cmd.bsel = BSEL_CHK;
               4'd8: begin
                  kind     = EMIT_NEWLINE;
                  cmd.last = cmd.ext_seg;
               end
               default: cmd.const_byte = 8'h00;
            endcase
            if (status.out_free) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == 4'd8) begin
                  cnt_in = '0;
                  if (cmd.ext_seg) begin
                     state_in = S_IDLE;
                  end else begin
                     cmd.clr_need_lin = 1'b1;
                     state_in = S_HEAD;
                  end
               end
            end
         end
         S_HEAD: begin
            kind = EMIT_HEX;
            case (cnt_ff)
               4'd0: kind = EMIT_COLON;
               4'd1: cmd.bsel = BSEL_LEN;
               4'd2: cmd.bsel = BSEL_ADDR_HI;
               4'd3: cmd.bsel = BSEL_ADDR_LO;
               default: cmd.bsel = BSEL_CONST;
            endcase
            if (status.out_free) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == 4'd4) begin
                  cnt_in   = '0;
                  state_in = S_BODY;
               end
            end
         end
         S_BODY: begin
            kind     = EMIT_HEX;
            cmd.bsel = BSEL_BUF;
            if (status.out_free) begin
               cnt_in = cnt_ff + 1'b1;
               if (body_end) begin
                  cnt_in   = '0;
                  state_in = S_TAIL;
               end
            end
         end
         S_TAIL: begin
            if (cnt_ff == '0) begin
               kind     = EMIT_HEX;
               cmd.bsel = BSEL_CHK;
               if (status.out_free) begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end else begin
               kind = EMIT_NEWLINE;
               // the data record ends the item unless a segment or end record follows
               cmd.last = (status.cmd == CMD_WRITE) || (status.cmd == CMD_ADDRESS) ||
                          (status.cmd == CMD_SEGMENT && !status.seg_diff);
               if (status.out_free) begin
                  cmd.flush_done = 1'b1;
                  cnt_in   = '0;
                  state_in = S_AFTER;
               end
            end
         end
         S_AFTER: begin
            cnt_in = '0;
            case (status.cmd)
               CMD_WRITE: begin
                  cmd.store = 1'b1;
                  state_in  = S_IDLE;
               end
               CMD_ADDRESS: begin
                  cmd.set_addr = 1'b1;
                  state_in     = S_IDLE;
               end
               CMD_SEGMENT: begin
                  cmd.set_addr = 1'b1;
                  if (status.seg_diff) begin
                     cmd.set_seg = 1'b1;
                     state_in    = S_EXT2;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               default: state_in = S_EOF;
            endcase
         end
         S_EOF: begin
            kind     = EMIT_HEX;
            cmd.bsel = BSEL_CONST;
            case (cnt_ff)
               4'd0: kind = EMIT_COLON;
               4'd4: cmd.const_byte = TYPE_EOF;
               4'd5: cmd.const_byte = 8'hFF;
               4'd6: begin
                  kind     = EMIT_NEWLINE;
                  cmd.last = 1'b1;
               end
               default: cmd.const_byte = 8'h00;
            endcase
            if (status.out_free) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == 4'd6) begin
                  cnt_in   = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
            cnt_in   = '0;
         end
      endcase

      cmd.emit = status.out_free ? kind : EMIT_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

### design/intel_hex_record_writer_core.sv
// top level of the hex record writer: controller plus datapath
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_data (command, data, address, segment)
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_data (up to two characters, pair, last)
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// a data byte that does not close a line gives no output
// otherwise one output unit leaves per cycle while the output is free: 9 for a type 04 or 02 record,
// fill + 7 for a data record, 7 for the end record
// the output register and the sequencer both wait on rsp_stall; the sequencer holds
// while the output is not free. reset clears address, segment, fill and sets line length 16 with cr lf endings
`default_nettype none
module intel_hex_record_writer_core #(
   parameter int MAX_LINE_LENGTH = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  hexrw_pkg::req_type     req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output hexrw_pkg::rsp_type     rsp_data,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire                    csr_index,
   input  wire  [7:0]             csr_data
);
   import hexrw_pkg::*;

   localparam int CNT_W = $clog2(MAX_LINE_LENGTH + 1);
   localparam int IDX_W = (MAX_LINE_LENGTH > 1) ? $clog2(MAX_LINE_LENGTH) : 1;

   dp_cmd_type       cmd;
   dp_status_type    status;
   logic [CNT_W-1:0] fill;
   logic [IDX_W-1:0] buf_idx;

   assign csr_ready = 1'b1;

   hexrw_ctrl #(
      .CNT_W           (CNT_W),
      .IDX_W           (IDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .fill      (fill),
      .cmd       (cmd),
      .buf_idx   (buf_idx)
   );

   hexrw_dp #(
      .MAX_LINE_LENGTH (MAX_LINE_LENGTH),
      .CNT_W           (CNT_W),
      .IDX_W           (IDX_W)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .buf_idx   (buf_idx),
      .status    (status),
      .fill      (fill),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

### verif/tb_top.sv
// self-checking testbench of the hex record writer: directed table, then random phases
`timescale 1ns / 1ps
module tb_top;
   import hexrw_pkg::*;

   localparam int MAX_LEN     = 16;
   localparam int SETTLE      = 12;
   localparam int HOLD_OFF    = 400;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 40;
   localparam int CYCLE_LIMIT = 2000000;
   localparam logic [7:0] TYPE_DATA = 8'h00;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_ALPHA = 8'h41;

   // one directed step: an item, or a format change made while idle
   typedef struct {
      bit      is_csr;
      int      len_val;
      int      crlf_val;
      req_type item;
      string   text;
   } plan_row_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_index;
   logic [7:0] csr_data;

   // encoder state kept by the testbench
   logic [7:0]  fmt_len  = DEFAULT_LINE_LENGTH;
   bit          fmt_crlf = 1'b1;
   logic [31:0] cur_addr = '0;
   logic [15:0] cur_seg  = '0;
   bit          need_lin = 1'b0;
   int          fill     = 0;
   logic [7:0]  line_bytes [MAX_LEN];

   rsp_type      step_units [$];
   rsp_type      awaited_units [$];
   string        quoted_text [$];
   plan_row_type plan [$];

   int          errors = 0;
   int          items_accepted = 0;
   int          units_seen = 0;
   int          csr_writes = 0;
   int          directed_items = 0;
   int          hold_offs = 0;
   int unsigned cycle_count = 0;
   bit          quiet = 1'b0;
   bit          hold_off_req = 1'b0;
   logic [15:0] gen_page = '0;
   logic [15:0] gen_seg = '0;
   int          phase_len [PHASES]  = '{0, 1, 255, 2, 16, 5, 17, 32};
   int          phase_crlf [PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0};

   intel_hex_record_writer_core #(.MAX_LINE_LENGTH(MAX_LEN)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [7:0] hex_char(input int d);
      return (d < 10) ? CHR_ZERO + 8'(d) : CHR_ALPHA + 8'(d - 10);
   endfunction

   function automatic void put_unit(input logic [7:0] c1, input logic [7:0] c2,
                                    input logic two);
      rsp_type u;
      u.first_char  = c1;
      u.second_char = c2;
      u.pair        = two;
      u.last        = 1'b0;
      step_units.push_back(u);
   endfunction

   function automatic void put_byte(input int b);
      put_unit(hex_char((b >> 4) & 15), hex_char(b & 15), 1'b1);
   endfunction

   function automatic void put_line_end();
      if (fmt_crlf) put_unit(CHR_CR, CHR_LF, 1'b1);
      else put_unit(CHR_LF, 8'h00, 1'b0);
   endfunction

   // type 02 and type 04 records carry one 16-bit word
   function automatic void put_record(input logic [7:0] kind, input logic [15:0] word);
      int sum;
      sum = 2 + kind + word[15:8] + word[7:0];
      put_unit(CHR_COLON, 8'h00, 1'b0);
      put_byte(2);
      put_byte(0);
      put_byte(0);
      put_byte(kind);
      put_byte(word[15:8]);
      put_byte(word[7:0]);
      put_byte(256 - (sum & 255));
      put_line_end();
   endfunction

   function automatic void flush_line();
      int lo16, sum, k;
      if (fill == 0) return;
      if (need_lin) begin
         put_record(TYPE_LINEAR, cur_addr[31:16]);
         need_lin = 1'b0;
      end
      lo16 = int'(cur_addr[15:0]);
      cur_addr = cur_addr + 32'(fill);
      // record ran past the top of the 64k page
      if (65535 - lo16 < fill) need_lin = 1'b1;
      sum = fill + (lo16 >> 8) + (lo16 & 255);
      put_unit(CHR_COLON, 8'h00, 1'b0);
      put_byte(fill);
      put_byte(lo16 >> 8);
      put_byte(lo16);
      put_byte(TYPE_DATA);
      for (k = 0; k < fill; k++) begin
         sum += line_bytes[k];
         put_byte(line_bytes[k]);
      end
      put_byte(256 - (sum & 255));
      put_line_end();
      fill = 0;
   endfunction

   function automatic void move_address(input logic [31:0] a);
      flush_line();
      if (cur_addr[31:16] != a[31:16]) need_lin = 1'b1;
      else if (cur_addr != {a[31:16], 16'h0000}) need_lin = 1'b0;
      cur_addr = a;
   endfunction

   function automatic void encode_item(input req_type r);
      int limit;
      step_units.delete();
      limit = (fmt_len == 0) ? int'(DEFAULT_LINE_LENGTH) : int'(fmt_len);
      if (limit > MAX_LEN) limit = MAX_LEN;
      case (r.command)
         CMD_WRITE: begin
            if (limit <= fill) flush_line();
            if (fill < MAX_LEN) begin
               line_bytes[fill] = r.data_byte;
               fill++;
            end
         end
         CMD_ADDRESS: begin
            move_address(r.address);
         end
         CMD_SEGMENT: begin
            move_address(r.address);
            if (cur_seg != r.segment) begin
               cur_seg = r.segment;
               put_record(TYPE_SEGMENT, r.segment);
            end
         end
         default: begin
            flush_line();
            put_unit(CHR_COLON, 8'h00, 1'b0);
            put_byte(0);
            put_byte(0);
            put_byte(0);
            put_byte(TYPE_EOF);
            put_byte(255);
            put_line_end();
         end
      endcase
   endfunction

   // typed-in records: '^' stands for cr lf, '|' for a lone lf
   function automatic void text_units(input string s);
      int  i;
      byte c;
      step_units.delete();
      i = 0;
      while (i < s.len()) begin
         c = s[i];
         if (c == ":") begin
            put_unit(CHR_COLON, 8'h00, 1'b0);
            i++;
         end else if (c == "^") begin
            put_unit(CHR_CR, CHR_LF, 1'b1);
            i++;
         end else if (c == "|") begin
            put_unit(CHR_LF, 8'h00, 1'b0);
            i++;
         end else begin
            put_unit(s[i], s[i + 1], 1'b1);
            i += 2;
         end
      end
   endfunction

   function automatic plan_row_type row_item(input logic [1:0] cmd, input logic [7:0] data,
                                             input logic [31:0] addr,
                                             input logic [15:0] seg, input string text);
      plan_row_type p;
      p.is_csr         = 1'b0;
      p.len_val        = -1;
      p.crlf_val       = -1;
      p.item.command   = cmd;
      p.item.data_byte = data;
      p.item.address   = addr;
      p.item.segment   = seg;
      p.text           = text;
      return p;
   endfunction

   function automatic plan_row_type row_csr(input int len_val, input int crlf_val);
      plan_row_type p;
      p = row_item(CMD_WRITE, 8'h00, 32'h0, 16'h0, "");
      p.is_csr   = 1'b1;
      p.len_val  = len_val;
      p.crlf_val = crlf_val;
      return p;
   endfunction

   // mostly near page ends, page starts and the current page, so records wrap
   function automatic logic [31:0] pick_address();
      logic [15:0] page;
      logic [31:0] a;
      page = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                         : gen_page + 16'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
         0, 1: a = {page, 16'hFFFF - 16'($urandom_range(0, 20))};
         2:    a = {page, 16'h0000};
         3:    a = {page, 16'($urandom)};
         default: a = $urandom;
      endcase
      gen_page = a[31:16];
      return a;
   endfunction

   function automatic req_type gen_item();
      req_type r;
      int      pick;
      r.command   = 2'($urandom_range(0, 3));
      r.data_byte = 8'($urandom);
      r.address   = $urandom;
      r.segment   = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 66) begin
         r.command = CMD_WRITE;
      end else if (pick < 80) begin
         r.command = CMD_ADDRESS;
         r.address = pick_address();
      end else if (pick < 92) begin
         r.command = CMD_SEGMENT;
         r.address = pick_address();
         if ($urandom_range(0, 2) == 0) r.segment = gen_seg;
         gen_seg = r.segment;
      end else if (pick < 97) begin
         r.command = CMD_END;
      end
      return r;
   endfunction

   task automatic send_item(input req_type r, input string text);
      int gap, pick;
      gap = 0;
      pick = $urandom_range(0, 99);
      if (!quiet) begin
         if (pick >= 97) gap = $urandom_range(20, 40);
         else if (pick >= 88) gap = $urandom_range(4, 10);
         else if (pick >= 60) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      quoted_text.push_back(text);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   // wait for every awaited unit, then give a byte still in the pipe time to land
   task automatic drain_outputs();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_units.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // a negative value leaves that register as it is
   task automatic configure(input int len_val, input int crlf_val);
      int vals [2];
      vals[CSR_LINE_LENGTH]  = len_val;
      vals[CSR_NEWLINE_CRLF] = crlf_val;
      drain_outputs();
      for (int i = 0; i < 2; i++) begin
         if (vals[i] >= 0) begin
            csr_valid <= 1'b1;
            csr_index <= 1'(i);
            csr_data  <= 8'(vals[i]);
            do @(posedge clock); while (!csr_ready);
            csr_writes++;
         end
      end
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : csr_side
      if (!reset && csr_valid && csr_ready) begin
         if (csr_index == CSR_LINE_LENGTH) fmt_len = csr_data;
         else fmt_crlf = csr_data[0];
      end
   end

   always @(posedge clock) begin : req_side
      string text;
      if (!reset && req_valid && !req_stall) begin
         encode_item(req_data);
         text = quoted_text.pop_front();
         if (text != "") text_units(text);
         if (step_units.size() != 0) step_units[step_units.size() - 1].last = 1'b1;
         foreach (step_units[k]) awaited_units.push_back(step_units[k]);
         items_accepted++;
      end
   end

   function automatic void note_error(input string what, input int want, input int got);
      errors++;
      if (errors <= 40)
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
   endfunction

   always @(posedge clock) begin : rsp_side
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         units_seen++;
         if (awaited_units.size() == 0) begin
            errors++;
            if (errors <= 40)
               $display("%0t: output unit expected none, got 0x%0h", $time, rsp_data);
         end else begin
            want = awaited_units.pop_front();
            if (rsp_data.first_char !== want.first_char)
               note_error("first_char", want.first_char, rsp_data.first_char);
            if (rsp_data.second_char !== want.second_char)
               note_error("second_char", want.second_char, rsp_data.second_char);
            if (rsp_data.pair !== want.pair)
               note_error("pair", want.pair, rsp_data.pair);
            if (rsp_data.last !== want.last)
               note_error("last", want.last, rsp_data.last);
         end
      end
   end

   // output side pacing: runs of stalls and of free flow, and the long hold-off
   initial begin : rsp_pacing
      int   span, pick;
      logic hold;
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold = 1'b1;
            span = HOLD_OFF;
            hold_offs++;
         end else if (quiet) begin
            hold = 1'b0;
            span = 1;
         end else begin
            pick = $urandom_range(0, 99);
            hold = (pick < 35);
            if (pick < 85) span = $urandom_range(1, 3);
            else if (pick < 97) span = $urandom_range(4, 12);
            else span = $urandom_range(20, 40);
         end
         rsp_stall <= hold;
         repeat (span) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached, %0d units still awaited",
                  $time, awaited_units.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= 1'b0;
      csr_data  <= '0;

      // end record from reset, segment extremes, a page change and a wrap past ffff
      plan.push_back(row_item(CMD_END, 8'h00, 32'h0000_0000, 16'h0000, ":00000001FF^"));
      plan.push_back(row_item(CMD_SEGMENT, 8'h00, 32'h0000_0000, 16'hFFFF,
                              ":02000002FFFFFE^"));
      plan.push_back(row_item(CMD_SEGMENT, 8'h00, 32'h0000_0000, 16'hFFFF, ""));
      plan.push_back(row_item(CMD_WRITE, 8'h00, 32'h0, 16'h0, ""));
      plan.push_back(row_item(CMD_WRITE, 8'hFF, 32'h0, 16'h0, ""));
      plan.push_back(row_item(CMD_WRITE, 8'hA5, 32'h0, 16'h0, ""));
      plan.push_back(row_item(CMD_WRITE, 8'h5A, 32'h0, 16'h0, ""));
      plan.push_back(row_item(CMD_ADDRESS, 8'h00, 32'h0001_FFFE, 16'h0,
                              ":0400000000FFA55AFE^"));
      plan.push_back(row_item(CMD_WRITE, 8'h11, 32'h0, 16'h0, ""));
      plan.push_back(row_item(CMD_WRITE, 8'h22, 32'h0, 16'h0, ""));
      plan.push_back(row_item(CMD_WRITE, 8'h33, 32'h0, 16'h0, ""));
      plan.push_back(row_item(CMD_WRITE, 8'h44, 32'h0, 16'h0, ""));
      plan.push_back(row_item(CMD_END, 8'h00, 32'h0, 16'h0,
                              ":020000040001F9^:04FFFE001122334455^:00000001FF^"));
      // wrap lands on a page start, so moving within that page keeps the type 04 pending
      plan.push_back(row_item(CMD_ADDRESS, 8'h00, 32'h0000_FFFE, 16'h0, ""));
      plan.push_back(row_item(CMD_WRITE, 8'h01, 32'h0, 16'h0, ""));
      plan.push_back(row_item(CMD_WRITE, 8'h02, 32'h0, 16'h0, ""));
      plan.push_back(row_item(CMD_ADDRESS, 8'h00, 32'h0001_0005, 16'h0,
                              ":020000040000FA^:02FFFE000102FE^"));
      plan.push_back(row_item(CMD_WRITE, 8'h7E, 32'h0, 16'h0, ""));
      plan.push_back(row_item(CMD_END, 8'h00, 32'h0, 16'h0,
                              ":020000040001F9^:010005007E7C^:00000001FF^"));
      // line length dropped below the fill level with lf endings
      plan.push_back(row_csr(-1, 0));
      plan.push_back(row_item(CMD_WRITE, 8'hC3, 32'h0, 16'h0, ""));
      plan.push_back(row_item(CMD_WRITE, 8'h3C, 32'h0, 16'h0, ""));
      plan.push_back(row_item(CMD_WRITE, 8'h99, 32'h0, 16'h0, ""));
      plan.push_back(row_csr(1, -1));
      plan.push_back(row_item(CMD_WRITE, 8'h0F, 32'h0, 16'h0, ":03000600C33C995F|"));
      plan.push_back(row_csr(255, 1));
      plan.push_back(row_item(CMD_SEGMENT, 8'h00, 32'hFFFF_FFFF, 16'h0000,
                              ":010009000FE7^:020000020000FC^"));
      plan.push_back(row_item(CMD_WRITE, 8'h00, 32'h0, 16'h0, ""));
      plan.push_back(row_item(CMD_END, 8'h00, 32'h0, 16'h0, ""));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            configure(plan[i].len_val, plan[i].crlf_val);
         end else begin
            send_item(plan[i].item, plan[i].text);
            directed_items++;
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         configure(phase_len[ph], phase_crlf[ph]);
         quiet = (ph == 3);
         // output held off while items keep coming, so the block backs up
         if (ph == 1) hold_off_req = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 5 && n == PHASE_ITEMS / 2) drain_outputs();
            send_item(gen_item(), "");
         end
      end
      quiet = 1'b0;
      drain_outputs();

      errors += awaited_units.size();
      $display("%0d items accepted (%0d directed), %0d output units compared",
               items_accepted, directed_items, units_seen);
      $display("%0d register writes across %0d line formats, %0d long output hold-off",
               csr_writes, PHASES, hold_offs);
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
